// ----- src/bav_pkg.sv -----
// Package for the barometric altitude and vertical speed block.
// Holds shared constants, the exp2 root table type and its elaboration-time builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bav_pkg;

    localparam int WINDOW_SIZE_DEF = 8;

    localparam logic [16:0] GROUND_RESET = 17'd101325;
    localparam logic [25:0] ALT_TOP      = 26'd44330000;
    localparam logic signed [27:0] ALT_LOW = -28'sd16000000;
    localparam logic [20:0] SPEED_LIM    = 21'd2000000;
    localparam logic [29:0] INV_EXP_Q32  = 30'd817310618;

    typedef logic [31:0] root_tab_t [0:31];

    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = xin;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry j holds 2^(2^-(j+1)) as Q31
    function automatic root_tab_t root_table();
        root_tab_t t;
        logic [63:0] s;
        s = 64'd1 << 32;
        for (int j = 0; j < 32; j++)
        begin
            s = isqrt64(s << 31);
            t[j] = s[31:0];
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- src/bav_div.sv -----
// Restoring divider for the speed quotient, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module bav_div #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 19
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] qd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;

    assign trial = {rem_reg, qd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            qd_reg  <= {qd_reg[DVD_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule
`default_nettype wire

// ----- src/baro_altitude_velocity_top.sv -----
// An empty pressure sum or zero ground pressure skips the log2 passes; a ratio of mean pressure
// over ground pressure that is 2 or more after raising to the power INV_EXP_Q32 skips exp2, and a
// zero interval sum skips the divider. Full item: two log2 passes (normalize shifts, then 32
// squarings each on the shared 32x32 multiplier), 32 exp2 steps, then a bit-serial division.
// One item at a time; s_tready is low from acceptance until the result item is taken.
// Reset: windows, sums, index and last altitude clear; ground_pressure returns to 101325.
`timescale 1ns / 1ps
`default_nettype none
module baro_altitude_velocity_top
    import bav_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pressure_sample[16:0], interval_ms[32:17]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // altitude_mm[26:0], speed_mm_s[48:27]
    output logic [1:0]       m_tuser    // speed_valid[0], speed_saturated[1]
);

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int LGN   = $clog2(WINDOW_SIZE);
    localparam int PS_W  = 17 + LGN;
    localparam int IS_W  = 16 + LGN;
    localparam int KVAL  = 1000 * WINDOW_SIZE;
    localparam int KW    = $clog2(KVAL + 1);
    localparam int MAG_W = 27;
    localparam int DVD_W = MAG_W + KW;
    localparam root_tab_t ROOTS = root_table();

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_NORM  = 5'd2;
    localparam logic [4:0] S_SQ    = 5'd3;
    localparam logic [4:0] S_LDONE = 5'd4;
    localparam logic [4:0] S_BASE  = 5'd5;
    localparam logic [4:0] S_EMAG0 = 5'd6;
    localparam logic [4:0] S_EMAG1 = 5'd7;
    localparam logic [4:0] S_EMAG2 = 5'd8;
    localparam logic [4:0] S_ESET  = 5'd9;
    localparam logic [4:0] S_EXP   = 5'd10;
    localparam logic [4:0] S_SCALE = 5'd11;
    localparam logic [4:0] S_PMUL  = 5'd12;
    localparam logic [4:0] S_PALT  = 5'd13;
    localparam logic [4:0] S_SPEED = 5'd14;
    localparam logic [4:0] S_SMUL  = 5'd15;
    localparam logic [4:0] S_DIV   = 5'd16;
    localparam logic [4:0] S_SFIN  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0]  state_reg;
    logic [16:0] ground_reg;
    logic [16:0] pwin_reg [WINDOW_SIZE];
    logic [15:0] iwin_reg [WINDOW_SIZE];
    logic [IDX_W-1:0] idx_reg;
    logic [PS_W-1:0]  psum_reg;
    logic [IS_W-1:0]  isum_reg;
    logic signed [26:0] last_reg;

    logic [31:0] m_reg;
    logic [31:0] frac_reg;
    logic [4:0]  p_reg;
    logic [4:0]  cnt_reg;
    logic        which_reg;
    logic [36:0] ln_reg;
    logic        neg_reg;
    logic [36:0] mag_reg;
    logic [63:0] mul_reg;
    logic [35:0] emag_reg;
    logic [4:0]  shift_reg;
    logic [31:0] f_reg;
    logic [31:0] acc_reg;
    logic signed [26:0] alt_reg;
    logic [MAG_W-1:0] smag_reg;
    logic        sneg_reg;

    logic signed [26:0] out_alt_reg;
    logic [21:0] out_speed_reg;
    logic        out_valid_reg;
    logic        out_sat_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [32:0] sq;
    logic [36:0] ld;
    logic [63:0] rnd;
    logic signed [28:0] alt_w;
    logic signed [27:0] diff_w;
    logic [DVD_W-1:0] quot;
    logic        div_start;
    logic        div_done;
    logic [16:0] in_p;
    logic [15:0] in_dt;
    logic        accept;

    assign in_p   = s_tdata[16:0];
    assign in_dt  = s_tdata[32:17];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign sq     = mul_p[63:31];
    assign ld     = {p_reg, frac_reg};
    assign rnd    = mul_reg + 64'h4000_0000;
    assign alt_w  = $signed({3'b000, ALT_TOP}) - $signed({2'b00, rnd[57:31]});
    assign diff_w = {alt_reg[26], alt_reg} - {last_reg[26], last_reg};
    assign div_start = (state_reg == S_SMUL);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_BASE:
            begin
                mul_a = {15'd0, ground_reg};
                mul_b = 32'(WINDOW_SIZE);
            end
            S_EMAG1:
            begin
                mul_a = mag_reg[31:0];
                mul_b = {2'b00, INV_EXP_Q32};
            end
            S_EMAG2:
            begin
                mul_a = {27'd0, mag_reg[36:32]};
                mul_b = {2'b00, INV_EXP_Q32};
            end
            S_EXP:
            begin
                mul_a = acc_reg;
                mul_b = ROOTS[cnt_reg];
            end
            S_PMUL:
            begin
                mul_a = acc_reg;
                mul_b = {6'd0, ALT_TOP};
            end
            S_SMUL:
            begin
                mul_a = 32'(smag_reg);
                mul_b = 32'(KVAL);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    bav_div #(
        .DVD_W(DVD_W),
        .DVS_W(IS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p[DVD_W-1:0]),
        .divisor  (isum_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // control, window and running-sum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ground_reg <= GROUND_RESET;
            idx_reg    <= '0;
            psum_reg   <= '0;
            isum_reg   <= '0;
            last_reg   <= '0;
            which_reg  <= 1'b0;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                pwin_reg[i] <= '0;
                iwin_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ground_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        psum_reg <= psum_reg - PS_W'(pwin_reg[idx_reg]) + PS_W'(in_p);
                        isum_reg <= isum_reg - IS_W'(iwin_reg[idx_reg]) + IS_W'(in_dt);
                        pwin_reg[idx_reg] <= in_p;
                        iwin_reg[idx_reg] <= in_dt;
                        if ({1'b0, idx_reg} + 1'b1 >= (IDX_W + 1)'(WINDOW_SIZE))
                        begin
                            idx_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        which_reg <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    if (psum_reg == '0 || ground_reg == '0)
                    begin
                        state_reg <= S_SPEED;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (m_reg[31])
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_LDONE;
                    end
                end
                S_LDONE:
                begin
                    which_reg <= 1'b1;
                    state_reg <= which_reg ? S_EMAG0 : S_BASE;
                end
                S_BASE:  state_reg <= S_NORM;
                S_EMAG0: state_reg <= S_EMAG1;
                S_EMAG1: state_reg <= S_EMAG2;
                S_EMAG2: state_reg <= S_ESET;
                S_ESET:
                begin
                    if (!neg_reg && emag_reg[35:32] != 4'd0)
                    begin
                        state_reg <= S_SPEED;
                    end
                    else
                    begin
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: state_reg <= S_PMUL;
                S_PMUL:  state_reg <= S_PALT;
                S_PALT:  state_reg <= S_SPEED;
                S_SPEED:
                begin
                    last_reg  <= alt_reg;
                    state_reg <= (isum_reg == '0) ? S_OUT : S_SMUL;
                end
                S_SMUL:  state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SFIN;
                    end
                end
                S_SFIN:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_START:
            begin
                m_reg    <= 32'(psum_reg);
                p_reg    <= 5'd31;
                frac_reg <= 32'd0;
                cnt_reg  <= 5'd0;
                if (psum_reg == '0)
                begin
                    alt_reg <= $signed({1'b0, ALT_TOP});
                end
                else
                begin
                    alt_reg <= ALT_LOW[26:0];
                end
            end
            S_NORM:
            begin
                if (!m_reg[31])
                begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    p_reg <= p_reg - 1'b1;
                end
            end
            S_SQ:
            begin
                frac_reg <= {frac_reg[30:0], sq[32]};
                m_reg    <= sq[32] ? sq[32:1] : sq[31:0];
                cnt_reg  <= cnt_reg + 1'b1;
            end
            S_LDONE:
            begin
                if (!which_reg)
                begin
                    ln_reg <= ld;
                end
            end
            S_BASE:
            begin
                m_reg    <= mul_p[31:0];
                p_reg    <= 5'd31;
                frac_reg <= 32'd0;
                cnt_reg  <= 5'd0;
            end
            S_EMAG0:
            begin
                neg_reg <= (ln_reg < ld);
                mag_reg <= (ln_reg < ld) ? (ld - ln_reg) : (ln_reg - ld);
            end
            S_EMAG1: mul_reg <= mul_p;
            S_EMAG2: emag_reg <= mul_p[35:0] + {4'd0, mul_reg[63:32]};
            S_ESET:
            begin
                acc_reg <= 32'h8000_0000;
                cnt_reg <= 5'd0;
                alt_reg <= ALT_LOW[26:0];
                if (!neg_reg)
                begin
                    shift_reg <= 5'd0;
                    f_reg     <= emag_reg[31:0];
                end
                else if (emag_reg[31:0] == 32'd0)
                begin
                    shift_reg <= {1'b0, emag_reg[35:32]};
                    f_reg     <= 32'd0;
                end
                else
                begin
                    shift_reg <= {1'b0, emag_reg[35:32]} + 5'd1;
                    f_reg     <= 32'd0 - emag_reg[31:0];
                end
            end
            S_EXP:
            begin
                if (f_reg[31])
                begin
                    acc_reg <= mul_p[62:31];
                end
                f_reg   <= {f_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_SCALE: acc_reg <= acc_reg >> shift_reg;
            S_PMUL:  mul_reg <= mul_p;
            S_PALT:
            begin
                if (alt_w < 29'(ALT_LOW))
                begin
                    alt_reg <= ALT_LOW[26:0];
                end
                else if (alt_w > $signed({3'b000, ALT_TOP}))
                begin
                    alt_reg <= $signed({1'b0, ALT_TOP});
                end
                else
                begin
                    alt_reg <= alt_w[26:0];
                end
            end
            S_SPEED:
            begin
                out_alt_reg   <= alt_reg;
                out_speed_reg <= 22'd0;
                out_valid_reg <= 1'b0;
                out_sat_reg   <= 1'b0;
                sneg_reg      <= diff_w[27];
                smag_reg      <= diff_w[27] ? MAG_W'(-diff_w) : MAG_W'(diff_w);
            end
            S_SFIN:
            begin
                out_valid_reg <= 1'b1;
                if (quot > DVD_W'(SPEED_LIM))
                begin
                    out_sat_reg   <= 1'b1;
                    out_speed_reg <= sneg_reg ? (22'd0 - {1'b0, SPEED_LIM})
                                              : {1'b0, SPEED_LIM};
                end
                else
                begin
                    out_sat_reg   <= 1'b0;
                    out_speed_reg <= sneg_reg ? (22'd0 - quot[21:0]) : quot[21:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, out_speed_reg, out_alt_reg};
    assign m_tuser  = {out_sat_reg, out_valid_reg};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output handshakes open together");

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> m_reg[31])
        else $error("log mantissa not normalized");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[48:27] == 22'd0 && !m_tuser[1]))
        else $error("invalid speed not forced to zero");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (last_reg == out_alt_reg))
        else $error("last altitude differs from output altitude");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide step");

endmodule
`default_nettype wire
